// ----- rtl/billboard_sprite_projector_unit_defines.svh -----
// Assertion macros for the billboard sprite projector.
`ifndef BILLBOARD_SPRITE_PROJECTOR_UNIT_DEFINES_SVH
`define BILLBOARD_SPRITE_PROJECTOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define BSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bsp assertion failed");
`define BSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bsp assertion failed");
`else
`define BSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/bsp_pkg.sv -----
// Shared constants, register indexes and helper functions of the sprite projector.
package bsp_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int POS_FRAC_DEF     = 8;
    localparam int GUARD_BITS       = 8;
    localparam int ATAN_ENTRIES     = 24;
    localparam int INV_GAIN         = 39797;
    localparam int XY_W             = 29;
    localparam int Z_W              = 33;
    localparam int BRG_W            = 34;
    localparam int DEPTH_W          = XY_W + 16 - 24;
    localparam int IN_W             = 144;
    localparam int OUT_W            = 88;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_W   = 3'd0,
        CFG_SCREEN_H   = 3'd1,
        CFG_PROJ_DIST  = 3'd2,
        CFG_PIX_TURN   = 3'd3,
        CFG_NEAR_LIMIT = 3'd4
    } t_cfg_idx;

    // arctan(2^-i) in 2^32 units per turn
    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] sat_s16(input logic signed [39:0] v);
        logic [15:0] r;
        if (v > 40'sd32767) begin
            r = 16'h7FFF;
        end else if (v < -40'sd32768) begin
            r = 16'h8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/bsp_rotate.sv -----
// Pipelined CORDIC rotator: one micro-rotation per stage.
module bsp_rotate import bsp_pkg::*; #(
    parameter int STEPS  = CORDIC_STEPS_DEF,
    parameter int SIDE_W = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic signed [XY_W-1:0] i_x,
    input  logic signed [XY_W-1:0] i_y,
    input  logic signed [Z_W-1:0]  i_z,
    input  logic [SIDE_W-1:0]      i_side,
    output logic                   o_valid,
    output logic signed [XY_W-1:0] o_x,
    output logic signed [XY_W-1:0] o_y,
    output logic [SIDE_W-1:0]      o_side
);

    logic                   r_vld  [STEPS];
    logic signed [XY_W-1:0] r_x    [STEPS];
    logic signed [XY_W-1:0] r_y    [STEPS];
    logic signed [Z_W-1:0]  r_z    [STEPS];
    logic [SIDE_W-1:0]      r_side [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_stage
        logic                   a_vld;
        logic signed [XY_W-1:0] a_x, a_y, a_xs, a_ys;
        logic signed [Z_W-1:0]  a_z, a_at;
        logic [SIDE_W-1:0]      a_side;
        if (k == 0) begin : g_first
            assign a_vld  = i_valid;
            assign a_x    = i_x;
            assign a_y    = i_y;
            assign a_z    = i_z;
            assign a_side = i_side;
        end else begin : g_next
            assign a_vld  = r_vld[k-1];
            assign a_x    = r_x[k-1];
            assign a_y    = r_y[k-1];
            assign a_z    = r_z[k-1];
            assign a_side = r_side[k-1];
        end
        assign a_xs = a_x >>> k;
        assign a_ys = a_y >>> k;
        assign a_at = $signed(Z_W'(atan_turn(k)));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= a_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!a_z[Z_W-1]) begin
                    r_x[k] <= a_x + a_ys;
                    r_y[k] <= a_y - a_xs;
                    r_z[k] <= a_z - a_at;
                end else begin
                    r_x[k] <= a_x - a_ys;
                    r_y[k] <= a_y + a_xs;
                    r_z[k] <= a_z + a_at;
                end
                r_side[k] <= a_side;
            end
        end
    end

    assign o_valid = r_vld[STEPS-1];
    assign o_x     = r_x[STEPS-1];
    assign o_y     = r_y[STEPS-1];
    assign o_side  = r_side[STEPS-1];

endmodule

// ----- rtl/bsp_vector.sv -----
// Pipelined CORDIC vectorer giving the bearing of a vector in 2^32 units per turn.
module bsp_vector import bsp_pkg::*; #(
    parameter int STEPS  = CORDIC_STEPS_DEF,
    parameter int SIDE_W = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [XY_W-1:0]  i_x,
    input  logic signed [XY_W-1:0]  i_y,
    input  logic [SIDE_W-1:0]       i_side,
    output logic                    o_valid,
    output logic signed [BRG_W-1:0] o_bearing,
    output logic [SIDE_W-1:0]       o_side
);

    localparam logic signed [BRG_W-1:0] HALF_TURN = BRG_W'(64'd1 << 31);

    logic                    r_vld  [STEPS+1];
    logic                    r_zero [STEPS+1];
    logic signed [XY_W-1:0]  r_u    [STEPS+1];
    logic signed [XY_W-1:0]  r_v    [STEPS+1];
    logic signed [BRG_W-1:0] r_b    [STEPS+1];
    logic [SIDE_W-1:0]       r_side [STEPS+1];

    // left half plane folds over by a half turn
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            r_side[0] <= i_side;
            if (i_x[XY_W-1]) begin
                r_b[0] <= i_y[XY_W-1] ? -HALF_TURN : HALF_TURN;
                r_u[0] <= -i_x;
                r_v[0] <= -i_y;
            end else begin
                r_b[0] <= '0;
                r_u[0] <= i_x;
                r_v[0] <= i_y;
            end
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_stage
        logic signed [XY_W-1:0]  a_us, a_vs;
        logic signed [BRG_W-1:0] a_at;
        logic                    a_pos;
        assign a_us  = r_u[k] >>> k;
        assign a_vs  = r_v[k] >>> k;
        assign a_at  = $signed(BRG_W'(atan_turn(k)));
        assign a_pos = !r_v[k][XY_W-1] && (r_v[k] != '0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (a_pos) begin
                    r_u[k+1] <= r_u[k] + a_vs;
                    r_v[k+1] <= r_v[k] - a_us;
                    r_b[k+1] <= r_b[k] + a_at;
                end else begin
                    r_u[k+1] <= r_u[k] - a_vs;
                    r_v[k+1] <= r_v[k] + a_us;
                    r_b[k+1] <= r_b[k] - a_at;
                end
                r_zero[k+1] <= r_zero[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid   = r_vld[STEPS];
    assign o_bearing = r_zero[STEPS] ? '0 : r_b[STEPS];
    assign o_side    = r_side[STEPS];

endmodule

// ----- rtl/bsp_divider.sv -----
// Pipelined restoring divider, one quotient bit per stage, saturating on overflow.
module bsp_divider #(
    parameter int HI_W   = 16,
    parameter int QUO_W  = 16,
    parameter int DEN_W  = 21,
    parameter int SIDE_W = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [HI_W+QUO_W-1:0]   i_num,
    input  logic [DEN_W-1:0]        i_den,
    input  logic [SIDE_W-1:0]       i_side,
    output logic                    o_valid,
    output logic [QUO_W-1:0]        o_quo,
    output logic [SIDE_W-1:0]       o_side
);

    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [CMP_W-1:0] w_hi, w_den;
    assign w_hi  = CMP_W'(i_num[HI_W+QUO_W-1:QUO_W]);
    assign w_den = CMP_W'(i_den);

    logic              r_vld  [QUO_W+1];
    logic              r_sat  [QUO_W+1];
    logic [DEN_W-1:0]  r_rem  [QUO_W+1];
    logic [DEN_W-1:0]  r_den  [QUO_W+1];
    logic [QUO_W-1:0]  r_low  [QUO_W+1];
    logic [SIDE_W-1:0] r_side [QUO_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    // quotient would not fit: covers a zero divisor too
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sat[0]  <= (w_hi >= w_den);
            r_rem[0]  <= w_hi[DEN_W-1:0];
            r_den[0]  <= i_den;
            r_low[0]  <= i_num[QUO_W-1:0];
            r_side[0] <= i_side;
        end
    end

    // dividend bits shift out of r_low while quotient bits shift in
    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [DEN_W:0] a_t, a_d;
        logic           a_ge;
        assign a_t  = {r_rem[k], r_low[k][QUO_W-1]};
        assign a_ge = (a_t >= {1'b0, r_den[k]});
        assign a_d  = a_t - {1'b0, r_den[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= a_ge ? a_d[DEN_W-1:0] : a_t[DEN_W-1:0];
                r_low[k+1]  <= {r_low[k][QUO_W-2:0], a_ge};
                r_sat[k+1]  <= r_sat[k];
                r_den[k+1]  <= r_den[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_vld[QUO_W];
    assign o_quo   = r_sat[QUO_W] ? '1 : r_low[QUO_W];
    assign o_side  = r_side[QUO_W];

endmodule

// ----- rtl/billboard_sprite_projector_unit.sv -----
// Top level of the billboard sprite projector: registers, stage glue and output.
//
//  channel   | dir | fields (lowest bit first)
//  ----------+-----+-----------------------------------------------------------
//  s_axis_*  | in  | sprite_x, sprite_y, viewer_x, viewer_y, viewer_heading,
//            |     | sprite_scale, vertical_shift, texture_width, texture_height
//  m_axis_*  | out | visible, depth, rect_x, rect_y, rect_width, rect_height
//  i_cfg_*   | in  | screen_width, screen_height, projection_distance,
//            |     | pixels_per_turn, near_limit
//
//  One item per cycle while the output is not stalled; the rotator, vectorer and
//  the two 16 bit dividers sit in series.
//  Reset clears all valid bits and loads the register defaults.
//  A stalled result freezes the whole pipeline; holes close only at the output.
`include "billboard_sprite_projector_unit_defines.svh"

module billboard_sprite_projector_unit import bsp_pkg::*; #(
    parameter int CORDIC_STEPS       = CORDIC_STEPS_DEF,
    parameter int POSITION_FRAC_BITS = POS_FRAC_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // sprite_x, sprite_y, viewer_x, viewer_y, viewer_heading, sprite_scale,
    // vertical_shift, texture_width, texture_height, zero pad
    input  logic [IN_W-1:0]       s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // visible, depth, rect_x, rect_y, rect_width, rect_height, zero pad
    output logic [OUT_W-1:0]      m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int NUM_SH = (POSITION_FRAC_BITS > 12) ? POSITION_FRAC_BITS - 12 : 0;
    localparam int DEN_SH = (POSITION_FRAC_BITS < 12) ? 12 - POSITION_FRAC_BITS : 0;
    localparam int N1_W   = 32 + NUM_SH;
    localparam int D1_W   = DEPTH_W + DEN_SH;
    localparam int PP_W   = BRG_W + 11;
    localparam int P_W    = PP_W + 11;
    localparam int COL_W  = 24;
    localparam int RX_W   = 27;
    localparam int SUM_W  = 36;
    localparam logic signed [P_W-1:0]   RND32 = P_W'((64'd1 << 32) - 64'd1);
    localparam logic signed [SUM_W-1:0] RND12 = SUM_W'(4095);

    typedef struct packed {
        logic [15:0]        scale;
        logic signed [15:0] shift;
        logic [12:0]        tex_w;
        logic [12:0]        tex_h;
    } t_geo;

    typedef struct packed {
        t_geo               geo;
        logic [DEPTH_W-1:0] depth;
    } t_vside;

    typedef struct packed {
        logic signed [COL_W-1:0] cols;
        logic [DEPTH_W-1:0]      depth;
        logic signed [15:0]      shift;
        logic [12:0]             tex_w;
        logic [12:0]             tex_h;
    } t_d1side;

    typedef struct packed {
        logic [15:0]             height;
        logic signed [COL_W-1:0] cols;
        logic [DEPTH_W-1:0]      depth;
        logic signed [15:0]      shift;
        logic [12:0]             tex_w;
    } t_d2side;

    // configuration registers
    logic [12:0] r_sw, r_sh;
    logic [15:0] r_pd, r_near;
    logic [19:0] r_ppt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw   <= 13'd1600;
            r_sh   <= 13'd900;
            r_pd   <= 16'd1386;
            r_ppt  <= 20'd9600;
            r_near <= 16'd128;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SCREEN_W:   r_sw   <= i_cfg_data[12:0];
                CFG_SCREEN_H:   r_sh   <= i_cfg_data[12:0];
                CFG_PROJ_DIST:  r_pd   <= i_cfg_data[15:0];
                CFG_PIX_TURN:   r_ppt  <= i_cfg_data;
                CFG_NEAR_LIMIT: r_near <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic w_en;
    logic r_out_vld;
    assign w_en          = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_en;

    // input stage: offset vector, whole quarter turns, residual angle
    logic signed [16:0]     w_dx, w_dy;
    logic signed [XY_W-1:0] w_x0, w_y0;
    logic [1:0]             w_quad;
    t_geo                   w_geo_in;

    assign w_dx   = 17'(signed'(s_axis_tdata[15:0])) - 17'(signed'(s_axis_tdata[47:32]));
    assign w_dy   = 17'(signed'(s_axis_tdata[63:48])) - 17'(signed'(s_axis_tdata[31:16]));
    assign w_x0   = XY_W'(w_dx) <<< GUARD_BITS;
    assign w_y0   = XY_W'(w_dy) <<< GUARD_BITS;
    assign w_quad = s_axis_tdata[79:78];

    assign w_geo_in.scale = s_axis_tdata[95:80];
    assign w_geo_in.shift = s_axis_tdata[111:96];
    assign w_geo_in.tex_w = s_axis_tdata[124:112];
    assign w_geo_in.tex_h = s_axis_tdata[137:125];

    logic                   r_s0_vld;
    logic signed [XY_W-1:0] r_s0_x, r_s0_y;
    logic signed [Z_W-1:0]  r_s0_z;
    t_geo                   r_s0_geo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (w_en) begin
            r_s0_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            case (w_quad)
                2'd0: begin r_s0_x <= w_x0;  r_s0_y <= w_y0;  end
                2'd1: begin r_s0_x <= w_y0;  r_s0_y <= -w_x0; end
                2'd2: begin r_s0_x <= -w_x0; r_s0_y <= -w_y0; end
                default: begin r_s0_x <= -w_y0; r_s0_y <= w_x0; end
            endcase
            r_s0_z   <= $signed(Z_W'({s_axis_tdata[77:64], 16'h0000}));
            r_s0_geo <= w_geo_in;
        end
    end

    logic                   w_r_vld;
    logic signed [XY_W-1:0] w_r_x, w_r_y;
    t_geo                   w_r_geo;

    bsp_rotate #(
        .STEPS  (CORDIC_STEPS),
        .SIDE_W ($bits(t_geo))
    ) u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s0_vld),
        .i_x     (r_s0_x),
        .i_y     (r_s0_y),
        .i_z     (r_s0_z),
        .i_side  (r_s0_geo),
        .o_valid (w_r_vld),
        .o_x     (w_r_x),
        .o_y     (w_r_y),
        .o_side  (w_r_geo)
    );

    // corrected depth from the along-heading component
    logic [XY_W-1:0]    w_along;
    logic [XY_W+15:0]   w_depth_prod;
    t_vside             w_vside_in;
    assign w_along          = w_r_x[XY_W-1] ? XY_W'(-w_r_x) : XY_W'(w_r_x);
    assign w_depth_prod     = (XY_W+16)'(w_along) * (XY_W+16)'(INV_GAIN);
    assign w_vside_in.geo   = w_r_geo;
    assign w_vside_in.depth = w_depth_prod[XY_W+15:24];

    logic                    w_v_vld;
    logic signed [BRG_W-1:0] w_v_brg;
    t_vside                  w_v_side;

    bsp_vector #(
        .STEPS  (CORDIC_STEPS),
        .SIDE_W ($bits(t_vside))
    ) u_vector (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (w_r_vld),
        .i_x       (w_r_x),
        .i_y       (w_r_y),
        .i_side    (w_vside_in),
        .o_valid   (w_v_vld),
        .o_bearing (w_v_brg),
        .o_side    (w_v_side)
    );

    // columns: bearing times columns per turn, split into two partial products
    logic                   r_c1_vld;
    logic signed [PP_W-1:0] r_c1_pp_lo, r_c1_pp_hi;
    logic [31:0]            r_c1_prod;
    t_vside                 r_c1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_vld <= 1'b0;
        end else if (w_en) begin
            r_c1_vld <= w_v_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c1_pp_lo <= PP_W'(w_v_brg) * $signed(PP_W'({1'b0, r_ppt[9:0]}));
            r_c1_pp_hi <= PP_W'(w_v_brg) * $signed(PP_W'({1'b0, r_ppt[19:10]}));
            r_c1_prod  <= 32'(r_pd) * 32'(w_v_side.geo.scale);
            r_c1_side  <= w_v_side;
        end
    end

    logic signed [P_W-1:0] w_p, w_cols;
    assign w_p    = P_W'(r_c1_pp_lo) + (P_W'(r_c1_pp_hi) <<< 10);
    assign w_cols = w_p[P_W-1] ? ((w_p + RND32) >>> 32) : (w_p >>> 32);

    logic        r_c2_vld;
    logic [31:0] r_c2_prod;
    t_d1side     r_c2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c2_vld <= 1'b0;
        end else if (w_en) begin
            r_c2_vld <= r_c1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c2_prod       <= r_c1_prod;
            r_c2_side.cols  <= w_cols[COL_W-1:0];
            r_c2_side.depth <= r_c1_side.depth;
            r_c2_side.shift <= r_c1_side.geo.shift;
            r_c2_side.tex_w <= r_c1_side.geo.tex_w;
            r_c2_side.tex_h <= r_c1_side.geo.tex_h;
        end
    end

    // height = distance * scale over depth, fraction bits lined up
    logic [N1_W-1:0] w_num1;
    logic [D1_W-1:0] w_den1;
    assign w_num1 = N1_W'(r_c2_prod) << NUM_SH;
    assign w_den1 = D1_W'(r_c2_side.depth) << DEN_SH;

    logic        w_d1_vld;
    logic [15:0] w_d1_quo;
    t_d1side     w_d1_side;

    bsp_divider #(
        .HI_W   (N1_W - 16),
        .QUO_W  (16),
        .DEN_W  (D1_W),
        .SIDE_W ($bits(t_d1side))
    ) u_div_height (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_c2_vld),
        .i_num   (w_num1),
        .i_den   (w_den1),
        .i_side  (r_c2_side),
        .o_valid (w_d1_vld),
        .o_quo   (w_d1_quo),
        .o_side  (w_d1_side)
    );

    // width = height * texture width / texture height
    logic [28:0] w_num2;
    logic [12:0] w_den2;
    t_d2side     w_d2_in;
    assign w_num2         = 29'(w_d1_quo) * 29'(w_d1_side.tex_w);
    assign w_den2         = (w_d1_side.tex_h == '0) ? 13'd1 : w_d1_side.tex_h;
    assign w_d2_in.height = w_d1_quo;
    assign w_d2_in.cols   = w_d1_side.cols;
    assign w_d2_in.depth  = w_d1_side.depth;
    assign w_d2_in.shift  = w_d1_side.shift;
    assign w_d2_in.tex_w  = w_d1_side.tex_w;

    logic        w_d2_vld;
    logic [15:0] w_d2_quo;
    t_d2side     w_d2_side;

    bsp_divider #(
        .HI_W   (13),
        .QUO_W  (16),
        .DEN_W  (13),
        .SIDE_W ($bits(t_d2side))
    ) u_div_width (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d1_vld),
        .i_num   (w_num2),
        .i_den   (w_den2),
        .i_side  (w_d2_in),
        .o_valid (w_d2_vld),
        .o_quo   (w_d2_quo),
        .o_side  (w_d2_side)
    );

    // rectangle corner and visibility
    logic signed [RX_W-1:0] w_rx, w_neg_tw, w_lim;
    assign w_rx     = $signed(RX_W'(r_sw[12:1])) - RX_W'(w_d2_side.cols)
                      - $signed(RX_W'(w_d2_quo[15:1]));
    assign w_neg_tw = -$signed(RX_W'(w_d2_side.tex_w));
    assign w_lim    = $signed(RX_W'(r_sw) + RX_W'(w_d2_side.tex_w));

    logic                   r_f1_vld;
    logic                   r_f1_vis;
    logic signed [RX_W-1:0] r_f1_rx;
    logic signed [17:0]     r_f1_base;
    logic signed [32:0]     r_f1_sprod;
    logic [DEPTH_W-1:0]     r_f1_depth;
    logic [15:0]            r_f1_width, r_f1_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
        end else if (w_en) begin
            r_f1_vld <= w_d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1_vis    <= (w_neg_tw < w_rx) && (w_rx < w_lim)
                           && (w_d2_side.depth > DEPTH_W'(r_near));
            r_f1_rx     <= w_rx;
            r_f1_base   <= $signed(18'(r_sh[12:1])) - $signed(18'(w_d2_side.height[15:1]));
            r_f1_sprod  <= 33'(w_d2_side.shift) * $signed(33'(w_d2_side.height));
            r_f1_depth  <= w_d2_side.depth;
            r_f1_width  <= w_d2_quo;
            r_f1_height <= w_d2_side.height;
        end
    end

    logic signed [SUM_W-1:0] w_sum, w_ry;
    assign w_sum = (SUM_W'(r_f1_base) <<< 12) + SUM_W'(r_f1_sprod);
    assign w_ry  = w_sum[SUM_W-1] ? ((w_sum + RND12) >>> 12) : (w_sum >>> 12);

    logic [OUT_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_f1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= {7'b0, r_f1_height, r_f1_width,
                           sat_s16(40'(w_ry)), sat_s16(40'(r_f1_rx)),
                           (r_f1_depth > DEPTH_W'(16'hFFFF)) ? 16'hFFFF : r_f1_depth[15:0],
                           r_f1_vis};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    `BSP_ASSERT_IMP(a_vis_depth, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[16:1] != 16'h0000)
    `BSP_ASSERT_IMP(a_zero_depth, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[16:1] == 16'h0000), m_axis_tdata[80:65] == 16'hFFFF)
    `BSP_ASSERT_NXT(a_rst_clear, i_clk, 1'b1, !i_rst_n, !m_axis_tvalid && s_axis_tready)

endmodule

// ----- tb/billboard_sprite_projector_unit_tb.sv -----
// Self-checking testbench of the billboard sprite projector: directed and random stream traffic, predicted results.
module billboard_sprite_projector_unit_tb;
    import bsp_pkg::*;

    typedef struct packed {
        logic [12:0] tex_h;
        logic [12:0] tex_w;
        logic [15:0] vshift;
        logic [15:0] scale;
        logic [15:0] heading;
        logic [15:0] vy;
        logic [15:0] vx;
        logic [15:0] sy;
        logic [15:0] sx;
    } sprite_t;

    typedef struct packed {
        logic [15:0] height;
        logic [15:0] width;
        logic [15:0] ry;
        logic [15:0] rx;
        logic [15:0] depth;
        logic        vis;
    } rect_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    billboard_sprite_projector_unit u_top (.*);

    longint scr_w, scr_h, proj_d, pix_turn, near_lim;
    sprite_t sprite_q[$];
    rect_t   rect_q[$];
    int      errors;
    bit      calm;
    bit      hold_long;
    int      src_gap, snk_gap;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic longint fshr(longint v, int n);
        if (v >= 0) return v >>> n;
        return -(((-v) - 1) >>> n) - 1;
    endfunction

    function automatic rect_t project(sprite_t s);
        rect_t  r;
        longint x, y, z, t, xs, ys, along, dep, brg, u, v, cols, hgt, wid, th, rx, base, ry;
        longint tw;
        x = (longint'($signed(s.sx)) - longint'($signed(s.vx))) * 256;
        y = (longint'($signed(s.vy)) - longint'($signed(s.sy))) * 256;
        for (int q = 0; q < int'(s.heading[15:14]); q++) begin
            t = x; x = y; y = -t;
        end
        z = longint'(s.heading[13:0]) << 16;
        for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
            xs = fshr(x, i); ys = fshr(y, i);
            if (z >= 0) begin x = x + ys; y = y - xs; z -= longint'(atan_turn(i)); end
            else begin x = x - ys; y = y + xs; z += longint'(atan_turn(i)); end
        end
        along = x < 0 ? -x : x;
        dep = (along * INV_GAIN) >>> 24;
        brg = 0;
        if (x != 0 || y != 0) begin
            u = x; v = y;
            if (u < 0) begin
                brg = (v >= 0) ? (64'sd1 <<< 31) : -(64'sd1 <<< 31);
                u = -u; v = -v;
            end
            for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
                xs = fshr(u, i); ys = fshr(v, i);
                if (v > 0) begin u = u + ys; v = v - xs; brg += longint'(atan_turn(i)); end
                else begin u = u - ys; v = v + xs; brg -= longint'(atan_turn(i)); end
            end
        end
        cols = (brg * pix_turn) / (64'sd1 <<< 32);
        if (dep == 0) hgt = 65535;
        else begin
            hgt = ((proj_d * longint'(s.scale)) << 8) / (dep << 12);
            if (hgt > 65535) hgt = 65535;
        end
        tw = longint'(s.tex_w);
        th = s.tex_h == 0 ? 1 : longint'(s.tex_h);
        wid = hgt * tw / th;
        if (wid > 65535) wid = 65535;
        rx = (scr_w >>> 1) - cols - (wid >>> 1);
        base = (scr_h >>> 1) - (hgt >>> 1);
        ry = (base * 4096 + longint'($signed(s.vshift)) * hgt) / 4096;
        r.vis = (-tw < rx) && (rx < scr_w + tw) && (dep > near_lim);
        r.depth = dep > 65535 ? 16'hFFFF : dep[15:0];
        r.rx = rx > 32767 ? 16'h7FFF : (rx < -32768 ? 16'h8000 : rx[15:0]);
        r.ry = ry > 32767 ? 16'h7FFF : (ry < -32768 ? 16'h8000 : ry[15:0]);
        r.width = wid[15:0];
        r.height = hgt[15:0];
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (sprite_q.size() > 0) begin
                s_axis_tdata <= IN_W'(sprite_q[0]);
                rect_q.insert(rect_q.size(), project(sprite_q.pop_front()));
                s_axis_tvalid <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0) src_gap <= $urandom_range(1, 3);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        rect_t got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            snk_gap <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[$bits(rect_t)-1:0];
                if (rect_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end else begin
                    want = rect_q.pop_front();
                    if (got.vis !== want.vis)
                        $display("%0t: visible exp %0d got %0d", $time, want.vis, got.vis);
                    if (got.depth !== want.depth)
                        $display("%0t: depth exp %0d got %0d", $time, want.depth, got.depth);
                    if (got.rx !== want.rx)
                        $display("%0t: rect_x exp %0d got %0d", $time,
                                 $signed(want.rx), $signed(got.rx));
                    if (got.ry !== want.ry)
                        $display("%0t: rect_y exp %0d got %0d", $time,
                                 $signed(want.ry), $signed(got.ry));
                    if (got.width !== want.width)
                        $display("%0t: rect_width exp %0d got %0d", $time, want.width, got.width);
                    if (got.height !== want.height)
                        $display("%0t: rect_height exp %0d got %0d", $time,
                                 want.height, got.height);
                    if (got !== want) errors++;
                end
            end
            if (hold_long) begin
                m_axis_tready <= 1'b0;
            end else if (snk_gap > 0) begin
                snk_gap <= snk_gap - 1;
                m_axis_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                snk_gap <= $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, longint val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SCREEN_W:   scr_w = val & 13'h1FFF;
            CFG_SCREEN_H:   scr_h = val & 13'h1FFF;
            CFG_PROJ_DIST:  proj_d = val & 16'hFFFF;
            CFG_PIX_TURN:   pix_turn = val & 20'hFFFFF;
            default:        near_lim = val & 16'hFFFF;
        endcase
    endtask

    task automatic drain();
        while (sprite_q.size() > 0 || rect_q.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic sprite_t rand_sprite(bit tiny);
        sprite_t s;
        s = '0;
        s.sx = 16'($urandom); s.sy = 16'($urandom); s.vx = 16'($urandom); s.vy = 16'($urandom);
        s.heading = 16'($urandom); s.scale = 16'($urandom); s.vshift = 16'($urandom);
        if (tiny) begin
            // keep the sprite near the viewer so heights stay in range
            s.vx = s.sx + 16'($signed(10'($urandom)));
            s.vy = s.sy + 16'($signed(10'($urandom)));
            s.scale = 16'($urandom_range(0, 16'h2000));
            s.vshift = 16'($signed(14'($urandom)));
        end
        s.tex_w = 13'($urandom_range(1, 4096));
        s.tex_h = 13'($urandom_range(1, 4096));
        if ($urandom_range(0, 15) == 0) s.tex_w = 13'($urandom);
        if ($urandom_range(0, 15) == 0) s.tex_h = 13'($urandom);
        return s;
    endfunction

    task automatic run_random(int n);
        for (int k = 0; k < n; k++)
            sprite_q.insert(sprite_q.size(), rand_sprite($urandom_range(0, 3) != 0));
    endtask

    initial begin
        sprite_t s;
        errors = 0; calm = 0; hold_long = 0;
        i_rst_n = 1'b0; s_axis_tvalid = 1'b0; s_axis_tdata = '0;
        m_axis_tready = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = CFG_SCREEN_W; i_cfg_data = '0;
        scr_w = 1600; scr_h = 900; proj_d = 1386; pix_turn = 9600; near_lim = 128;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: coincident, extremes, quarter and half turns, zero texture height
        s = '0; s.tex_w = 13'd1; s.tex_h = 13'd1; s.scale = 16'h1000;
        sprite_q.insert(sprite_q.size(), s);
        s.sx = 16'h7FFF; s.vx = 16'h8000; sprite_q.insert(sprite_q.size(), s);
        s.sx = 16'h8000; s.vx = 16'h7FFF; s.sy = 16'h7FFF; s.vy = 16'h8000;
        s.heading = 16'hFFFF; s.scale = 16'hFFFF; s.vshift = 16'h7FFF;
        s.tex_w = 13'd4096; s.tex_h = 13'd4096; sprite_q.insert(sprite_q.size(), s);
        s.vshift = 16'h8000; s.tex_h = '0; s.tex_w = 13'h1FFF;
        sprite_q.insert(sprite_q.size(), s);
        for (int h = 0; h < 4; h++) begin
            s = '0; s.sx = 16'h0100; s.heading = 16'(h * 16384);
            s.scale = 16'h1000; s.tex_w = 13'd64; s.tex_h = 13'd64;
            sprite_q.insert(sprite_q.size(), s);
            s.sx = 16'hFF00; sprite_q.insert(sprite_q.size(), s);
        end
        s = '0; s.sx = 16'h0001; s.scale = 16'hFFFF; s.tex_w = 13'd4096; s.tex_h = 13'd1;
        sprite_q.insert(sprite_q.size(), s);
        s.sx = 16'h0000; s.sy = 16'h0080; s.heading = 16'h8000;
        sprite_q.insert(sprite_q.size(), s);
        run_random(8);
        drain();

        // long receiver hold while sender keeps offering
        hold_long = 1;
        run_random(150);
        repeat (400) @(posedge i_clk);
        hold_long = 0;
        drain();

        write_reg(CFG_SCREEN_W, 1); write_reg(CFG_SCREEN_H, 1);
        write_reg(CFG_PROJ_DIST, 1); write_reg(CFG_PIX_TURN, 1);
        write_reg(CFG_NEAR_LIMIT, 0);
        run_random(200);
        drain();

        write_reg(CFG_SCREEN_W, 4096); write_reg(CFG_SCREEN_H, 4096);
        write_reg(CFG_PROJ_DIST, 65535); write_reg(CFG_PIX_TURN, 1048575);
        write_reg(CFG_NEAR_LIMIT, 65535);
        run_random(200);
        drain();

        write_reg(CFG_SCREEN_W, $urandom_range(1, 4096));
        write_reg(CFG_SCREEN_H, $urandom_range(1, 4096));
        write_reg(CFG_PROJ_DIST, $urandom_range(1, 65535));
        write_reg(CFG_PIX_TURN, $urandom_range(1, 1048575));
        write_reg(CFG_NEAR_LIMIT, $urandom_range(0, 1024));
        run_random(250);
        drain();

        calm = 1;
        run_random(200);
        drain();

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
